>>> rtl/assert_macros.svh
// Assertion macros for the color string parser RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond implies expr in the same cycle, outside reset
`define CSP_ASSERT_SAME(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("color parser check failed");

// Check that cond implies expr in the next cycle, outside reset
`define CSP_ASSERT_NEXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("color parser check failed");

`endif

>>> rtl/csp_pkg.sv
// Types, constants and the color name table of the color string parser
`timescale 1ns / 1ps

package csp_pkg;

   // Token buffer size and derived widths
   localparam int MAX_TOKEN = 11;
   localparam int LEN_W     = $clog2(MAX_TOKEN + 1);
   localparam int IDX_W     = $clog2(MAX_TOKEN);

   // Character codes
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_HASH     = 8'h23;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] CH_LOWER_A  = 8'h61;
   localparam logic [7:0] CH_LOWER_F  = 8'h66;
   localparam logic [7:0] CH_UPPER_A  = 8'h41;
   localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;
   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   // Color name table, names right-justified in NAME_W bytes
   localparam int NAME_COUNT = 18;
   localparam int NAME_W     = 11;

   localparam logic [8*NAME_W-1:0] NAME_TEXT [NAME_COUNT] = '{
      "transparent", "none", "black", "white", "gray", "grey", "red", "green",
      "blue", "yellow", "cyan", "magenta", "orange", "purple", "pink", "brown",
      "navy", "coral"
   };

   localparam int NAME_LEN [NAME_COUNT] = '{
      11, 4, 5, 5, 4, 4, 3, 5, 4, 6, 4, 7, 6, 6, 4, 5, 4, 5
   };

   localparam logic [31:0] NAME_ARGB [NAME_COUNT] = '{
      32'h00000000, 32'h00000000, 32'hFF000000, 32'hFFFFFFFF,
      32'hFF808080, 32'hFF808080, 32'hFFFF0000, 32'hFF008000,
      32'hFF0000FF, 32'hFFFFFF00, 32'hFF00FFFF, 32'hFFFF00FF,
      32'hFFFFA500, 32'hFF800080, 32'hFFFFC0CB, 32'hFFA52A2A,
      32'hFF000080, 32'hFFFF7F50
   };

   typedef logic [7:0] char_type;
   typedef char_type [MAX_TOKEN-1:0] chars_type;

   // One registered input item as seen by the token and result stages
   typedef struct packed {
      logic     fire;   // item leaves the input register this cycle
      logic     last;
      logic     blank;
      char_type ch;     // case-folded byte
   } item_type;

   // Token including the byte that is leaving the input register
   typedef struct packed {
      logic             broken;
      logic [LEN_W-1:0] length;
      chars_type        chars;
   } tok_type;

endpackage

>>> rtl/csp_if.sv
// Handshake channel interfaces for the color string parser
`timescale 1ns / 1ps

interface csp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       last;

   modport source (output valid, output ch, output last, input ready);
   modport sink (input valid, input ch, input last, output ready);
endinterface

interface csp_rsp_if;
   logic        valid;
   logic        ready;
   logic        valid_res;
   logic [31:0] argb;

   modport source (output valid, output valid_res, output argb, input ready);
   modport sink (input valid, input valid_res, input argb, output ready);
endinterface

>>> rtl/csp_in_stage.sv
// Input register: folds case, flags whitespace and holds one item
`timescale 1ns / 1ps

module csp_in_stage (
   input  logic              clock,
   input  logic              reset,
   csp_req_if.sink           req,
   input  logic              rsp_free,
   output csp_pkg::item_type item
);
   import csp_pkg::*;

   logic     valid_ff;
   logic     last_ff;
   logic     blank_ff;
   char_type ch_ff;
   char_type ch_fold;
   logic     blank_in;
   logic     advance;
   logic     in_ready;

   // Fold upper case and detect whitespace on the incoming byte
   always_comb begin
      ch_fold = req.ch;
      if (req.ch >= CH_UPPER_A && req.ch <= CH_UPPER_Z) begin
         ch_fold = req.ch + CASE_OFFSET;
      end
      blank_in = (req.ch == CH_SPACE) || (req.ch >= CH_TAB && req.ch <= CH_CR);
   end

   // Advance unless a final item waits for a full result register
   assign advance   = valid_ff && (!last_ff || rsp_free);
   assign in_ready  = !valid_ff || advance;
   assign req.ready = in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= req.valid;
      end
   end

   // Hold the item payload
   always_ff @(posedge clock) begin
      if (req.valid && in_ready) begin
         last_ff  <= req.last;
         blank_ff <= blank_in;
         ch_ff    <= ch_fold;
      end
   end

   assign item.fire  = advance;
   assign item.last  = last_ff;
   assign item.blank = blank_ff;
   assign item.ch    = ch_ff;

endmodule

>>> rtl/csp_token.sv
// Token accumulator: keeps content bytes and the whitespace flags
`timescale 1ns / 1ps

module csp_token (
   input  logic              clock,
   input  logic              reset,
   input  csp_pkg::item_type item,
   output csp_pkg::tok_type  tok
);
   import csp_pkg::*;

   chars_type        chars_ff;
   logic [LEN_W-1:0] len_ff;
   logic [LEN_W-1:0] len_in;
   logic             content_ff;
   logic             content_in;
   logic             space_ff;
   logic             space_in;
   logic             broken_ff;
   logic             broken_in;
   logic             has_room;
   logic             write_en;

   assign has_room = len_ff < LEN_W'(MAX_TOKEN);
   assign write_en = item.fire && !item.blank && has_room;

   // Merge the current byte into the token seen by the result stage
   always_comb begin
      tok.chars  = chars_ff;
      tok.length = len_ff;
      tok.broken = broken_ff;
      if (!item.blank) begin
         if (space_ff) begin
            tok.broken = 1'b1;
         end
         if (has_room) begin
            tok.chars[len_ff[IDX_W-1:0]] = item.ch;
            tok.length = len_ff + LEN_W'(1);
         end else begin
            tok.broken = 1'b1;
         end
      end
   end

   // Next state: advance on each item, clear after the final one
   always_comb begin
      len_in     = len_ff;
      content_in = content_ff;
      space_in   = space_ff;
      broken_in  = broken_ff;
      if (item.fire) begin
         if (item.last) begin
            len_in     = '0;
            content_in = 1'b0;
            space_in   = 1'b0;
            broken_in  = 1'b0;
         end else begin
            len_in     = tok.length;
            broken_in  = tok.broken;
            content_in = content_ff || !item.blank;
            space_in   = space_ff || (item.blank && content_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= '0;
         content_ff <= 1'b0;
         space_ff   <= 1'b0;
         broken_ff  <= 1'b0;
      end else begin
         len_ff     <= len_in;
         content_ff <= content_in;
         space_ff   <= space_in;
         broken_ff  <= broken_in;
      end
   end

   // Store a content byte while there is room
   always_ff @(posedge clock) begin
      if (write_en) begin
         chars_ff[len_ff[IDX_W-1:0]] <= item.ch;
      end
   end

endmodule

>>> rtl/csp_eval.sv
// Result stage: matches names, decodes hex and holds the result item
`timescale 1ns / 1ps

module csp_eval (
   input  logic              clock,
   input  logic              reset,
   input  csp_pkg::item_type item,
   input  csp_pkg::tok_type  tok,
   output logic              rsp_free,
   csp_rsp_if.source         rsp
);
   import csp_pkg::*;

   logic        valid_ff;
   logic        res_ff;
   logic [31:0] argb_ff;
   logic [32:0] eval_out;
   logic        load;

   // Value of a hex digit, bit 4 set when the byte is not one
   function automatic logic [4:0] hex_digit(char_type c);
      logic [4:0] v;
      v = 5'h10;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         v = {1'b0, 4'(c - CH_ZERO)};
      end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
         v = {1'b0, 4'(c - CH_LOWER_A + 8'd10)};
      end
      return v;
   endfunction

   // Return {valid, argb} for a complete token
   function automatic logic [32:0] eval_token(tok_type t);
      logic        found;
      logic        eq;
      logic [31:0] name_argb;
      logic [31:0] hex_argb;
      logic [4:0]  dv [8];
      logic        bad3;
      logic        bad6;
      logic        bad8;
      logic        is3;
      logic        is6;
      logic        is8;
      logic        hex_ok;
      logic [7:0]  alpha;
      char_type    nb;
      int          sh;
      found     = 1'b0;
      name_argb = '0;
      for (int k = 0; k < NAME_COUNT; k++) begin
         eq = (t.length == LEN_W'(NAME_LEN[k]));
         for (int p = 0; p < NAME_W; p++) begin
            sh = (p < NAME_LEN[k]) ? (NAME_LEN[k] - 1 - p) : 0;
            nb = 8'(NAME_TEXT[k] >> (8 * sh));
            if (p < NAME_LEN[k] && t.chars[p] != nb) begin
               eq = 1'b0;
            end
         end
         if (eq && !found) begin
            found     = 1'b1;
            name_argb = NAME_ARGB[k];
         end
      end

      for (int i = 0; i < 8; i++) begin
         dv[i] = hex_digit(t.chars[i + 1]);
      end
      bad3 = dv[0][4] | dv[1][4] | dv[2][4];
      bad6 = bad3 | dv[3][4] | dv[4][4] | dv[5][4];
      bad8 = bad6 | dv[6][4] | dv[7][4];
      is3  = (t.length == LEN_W'(4));
      is6  = (t.length == LEN_W'(7));
      is8  = (t.length == LEN_W'(9));
      hex_ok = (t.chars[0] == CH_HASH) &&
               ((is3 && !bad3) || (is6 && !bad6) || (is8 && !bad8));
      alpha = is8 ? {dv[6][3:0], dv[7][3:0]} : ALPHA_OPAQUE;
      if (is3) begin
         hex_argb = {ALPHA_OPAQUE, dv[0][3:0], dv[0][3:0], dv[1][3:0], dv[1][3:0],
                     dv[2][3:0], dv[2][3:0]};
      end else begin
         hex_argb = {alpha, dv[0][3:0], dv[1][3:0], dv[2][3:0], dv[3][3:0],
                     dv[4][3:0], dv[5][3:0]};
      end

      priority if (t.broken || t.length == '0) begin
         return {1'b0, 32'h0};
      end else if (found) begin
         return {1'b1, name_argb};
      end else if (hex_ok) begin
         return {1'b1, hex_argb};
      end else begin
         return {1'b0, 32'h0};
      end
   endfunction

   assign eval_out = eval_token(tok);
   assign load     = item.fire && item.last;
   assign rsp_free = !valid_ff || rsp.ready;

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff  <= eval_out[32];
         argb_ff <= eval_out[31:0];
      end
   end

   assign rsp.valid     = valid_ff;
   assign rsp.valid_res = res_ff;
   assign rsp.argb      = argb_ff;

endmodule

>>> rtl/color_string_parser_core.sv
// Top level of the color string parser
//
//   Channel  Dir  Payload                 Handshake
//   req      in   ch[7:0], last           valid / ready
//   rsp      out  valid_res, argb[31:0]   valid / ready
//
// One byte is accepted per cycle while req.ready is high. Each byte is registered in the
// input register; when the final byte leaves it, the result is registered in the output
// register in the next cycle, so rsp.valid rises after the input and output registers.
// The name compares and hex decode are combinational ahead of the output register. Reset
// is synchronous and clears the token state. A stalled rsp only holds req.ready low once
// a final byte waits in the input register; other bytes keep flowing.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module color_string_parser_core (
   input logic       clock,
   input logic       reset,
   csp_req_if.sink   req,
   csp_rsp_if.source rsp
);
   import csp_pkg::*;

   item_type item;
   tok_type  tok;
   logic     rsp_free;

   csp_in_stage u_in (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .rsp_free (rsp_free),
      .item     (item)
   );

   csp_token u_token (
      .clock (clock),
      .reset (reset),
      .item  (item),
      .tok   (tok)
   );

   csp_eval u_eval (
      .clock    (clock),
      .reset    (reset),
      .item     (item),
      .tok      (tok),
      .rsp_free (rsp_free),
      .rsp      (rsp)
   );

   // An invalid result carries a zero color
   `CSP_ASSERT_SAME(a_invalid_zero, rsp.valid && !rsp.valid_res, rsp.argb == 32'h0)
   // Input stalls only behind a final item blocked by a full result register
   `CSP_ASSERT_SAME(a_stall_cause, !req.ready, item.last && rsp.valid && !rsp.ready)
   // A final item leaving the input register shows a result next cycle
   `CSP_ASSERT_NEXT(a_result_follows, item.fire && item.last, rsp.valid)

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the color string parser core
`timescale 1ns / 1ps

module tb_top;

   // Token buffer size and character codes
   localparam int TOKEN_CAP = 11;
   localparam logic [7:0] CHR_SPACE  = 8'h20;
   localparam logic [7:0] CHR_TAB    = 8'h09;
   localparam logic [7:0] CHR_LF     = 8'h0A;
   localparam logic [7:0] CHR_VT     = 8'h0B;
   localparam logic [7:0] CHR_FF     = 8'h0C;
   localparam logic [7:0] CHR_CR     = 8'h0D;
   localparam logic [7:0] CHR_HASH   = 8'h23;
   localparam logic [7:0] CHR_UP_A   = 8'h41;
   localparam logic [7:0] CHR_UP_Z   = 8'h5A;
   localparam logic [7:0] CASE_SHIFT = 8'h20;
   localparam logic [7:0] CHR_BANG   = 8'h21;
   localparam logic [7:0] CHR_NUL    = 8'h00;
   localparam logic [7:0] CHR_TOP    = 8'hFF;
   localparam int NAME_TOTAL = 18;
   localparam int NO_DIGIT   = 16;
   localparam int PHASE_CHARS = 400;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } char_item_type;

   typedef struct packed {
      logic        ok;
      logic [31:0] argb;
   } color_result_type;

   // Known color names and their words
   string color_names [NAME_TOTAL] = '{
      "transparent", "none", "black", "white", "gray", "grey", "red", "green",
      "blue", "yellow", "cyan", "magenta", "orange", "purple", "pink", "brown",
      "navy", "coral"
   };
   logic [31:0] color_argb [NAME_TOTAL] = '{
      32'h00000000, 32'h00000000, 32'hFF000000, 32'hFFFFFFFF,
      32'hFF808080, 32'hFF808080, 32'hFFFF0000, 32'hFF008000,
      32'hFF0000FF, 32'hFFFFFF00, 32'hFF00FFFF, 32'hFFFF00FF,
      32'hFFFFA500, 32'hFF800080, 32'hFFFFC0CB, 32'hFFA52A2A,
      32'hFF000080, 32'hFFFF7F50
   };
   logic [7:0] blank_set [6] = '{CHR_SPACE, CHR_TAB, CHR_LF, CHR_VT, CHR_FF, CHR_CR};
   string hex_chars = "0123456789abcdefABCDEF";

   logic clock = 1'b0;
   logic reset = 1'b1;

   csp_req_if req_ch ();
   csp_rsp_if rsp_ch ();

   color_string_parser_core i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always #2 clock = ~clock;

   // Shared state of stimulus, token tracking and checking
   char_item_type    chars_pending [$];
   color_result_type colors_due [$];
   logic [7:0]       draft [$];
   char_item_type    next_char;
   color_result_type got_color;
   color_result_type want_color;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int phase_chars   = 0;
   int mismatch_count = 0;

   logic [7:0] tok_buf [TOKEN_CAP];
   int tok_len    = 0;
   bit tok_seen   = 0;
   bit tok_gap    = 0;
   bit tok_broken = 0;

   // Print one mismatch line and count it
   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("[%0t] MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   function automatic logic [7:0] fold_case(logic [7:0] c);
      if (c >= CHR_UP_A && c <= CHR_UP_Z) return c + CASE_SHIFT;
      return c;
   endfunction

   function automatic bit is_blank(logic [7:0] c);
      return c == CHR_SPACE || (c >= CHR_TAB && c <= CHR_CR);
   endfunction

   // Nibble value of a folded hex digit, NO_DIGIT otherwise
   function automatic int nibble_of(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      return NO_DIGIT;
   endfunction

   // Resolve the collected token into a color word
   function automatic color_result_type judge_token();
      color_result_type r;
      logic [3:0] nib [8];
      bit hit;
      int n;
      int v;
      r = '0;
      if (tok_broken || tok_len == 0) return r;
      for (int k = 0; k < NAME_TOTAL; k++) begin
         if (color_names[k].len() == tok_len) begin
            hit = 1;
            for (int i = 0; i < tok_len; i++) begin
               if (tok_buf[i] != color_names[k][i]) hit = 0;
            end
            if (hit) begin
               r.ok = 1'b1;
               r.argb = color_argb[k];
               return r;
            end
         end
      end
      if (tok_len < 2 || tok_buf[0] != CHR_HASH) return r;
      n = tok_len - 1;
      if (n != 3 && n != 6 && n != 8) return r;
      for (int i = 0; i < n; i++) begin
         v = nibble_of(tok_buf[i + 1]);
         if (v == NO_DIGIT) return r;
         nib[i] = v[3:0];
      end
      r.ok = 1'b1;
      case (n)
         3: r.argb = {8'hFF, nib[0], nib[0], nib[1], nib[1], nib[2], nib[2]};
         6: r.argb = {8'hFF, nib[0], nib[1], nib[2], nib[3], nib[4], nib[5]};
         default: r.argb = {nib[6], nib[7], nib[0], nib[1], nib[2], nib[3], nib[4], nib[5]};
      endcase
      return r;
   endfunction

   // Fold one accepted byte into the token; on the final byte queue the color
   function automatic void absorb_char(logic [7:0] raw, logic fin);
      logic [7:0] c;
      c = fold_case(raw);
      if (is_blank(c)) begin
         if (tok_seen) tok_gap = 1;
      end else begin
         if (tok_gap) tok_broken = 1;
         tok_seen = 1;
         if (tok_len < TOKEN_CAP) begin
            tok_buf[tok_len] = c;
            tok_len++;
         end else begin
            tok_broken = 1;
         end
      end
      if (fin) begin
         colors_due.push_back(judge_token());
         tok_len    = 0;
         tok_seen   = 0;
         tok_gap    = 0;
         tok_broken = 0;
      end
   endfunction

   // Move the draft string into the pending items, flag on its final byte
   function automatic void flush_draft();
      char_item_type it;
      foreach (draft[i]) begin
         it.ch = draft[i];
         it.last = (i == draft.size() - 1);
         chars_pending.push_back(it);
      end
      phase_chars += draft.size();
      draft.delete();
   endfunction

   function automatic void add_text(string s, bit mixed);
      logic [7:0] c;
      for (int i = 0; i < s.len(); i++) begin
         c = s[i];
         if (mixed && c >= "a" && c <= "z" && $urandom_range(1)) c = c - CASE_SHIFT;
         draft.push_back(c);
      end
   endfunction

   function automatic void add_pad(int most);
      repeat ($urandom_range(most)) draft.push_back(blank_set[$urandom_range(5)]);
   endfunction

   function automatic void add_hex(int n);
      repeat (n) draft.push_back(hex_chars[$urandom_range(hex_chars.len() - 1)]);
   endfunction

   function automatic int pick_hex_len();
      case ($urandom_range(2))
         0: return 3;
         1: return 6;
         default: return 8;
      endcase
   endfunction

   // One random string: mostly well-formed names and hex, the rest broken
   function automatic void queue_random_string();
      int kind;
      int n;
      int spot;
      logic [7:0] b;
      kind = $urandom_range(99);
      add_pad(2);
      if (kind < 35) begin
         add_text(color_names[$urandom_range(NAME_TOTAL - 1)], 1);
      end else if (kind < 70) begin
         draft.push_back(CHR_HASH);
         add_hex(pick_hex_len());
      end else begin
         case ($urandom_range(5))
            0: repeat ($urandom_range(1, 14)) draft.push_back(8'($urandom_range(255)));
            1: begin
               if ($urandom_range(3) != 0) draft.push_back(CHR_HASH);
               add_hex($urandom_range(10));
            end
            2: begin
               n = pick_hex_len();
               spot = $urandom_range(n - 1);
               draft.push_back(CHR_HASH);
               add_hex(spot);
               do b = 8'($urandom_range(255));
               while (nibble_of(fold_case(b)) != NO_DIGIT || is_blank(b));
               draft.push_back(b);
               add_hex(n - 1 - spot);
            end
            3: begin
               add_text(color_names[$urandom_range(NAME_TOTAL - 1)], 1);
               draft.push_back(blank_set[$urandom_range(5)]);
               add_pad(1);
               add_text(color_names[$urandom_range(NAME_TOTAL - 1)], 1);
            end
            4: begin
               if ($urandom_range(1)) begin
                  add_text("transparent", 1);
                  add_hex($urandom_range(1, 3));
               end else begin
                  draft.push_back(CHR_HASH);
                  add_hex($urandom_range(11, 13));
               end
            end
            default: add_pad(3);
         endcase
      end
      add_pad(2);
      if (draft.size() == 0) draft.push_back(blank_set[$urandom_range(5)]);
      flush_draft();
   endfunction

   // Hold each item until taken; track accepted items
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) absorb_char(req_ch.ch, req_ch.last);
         if (!req_ch.valid || req_ch.ready) begin
            if (chars_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_char = chars_pending.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.ch    <= next_char.ch;
               req_ch.last  <= next_char.last;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Check each delivered color against the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got_color.ok   = rsp_ch.valid_res;
            got_color.argb = rsp_ch.argb;
            if (colors_due.size() == 0) begin
               report_mismatch("unexpected result", got_color.argb, 32'h0);
            end else begin
               want_color = colors_due.pop_front();
               if (got_color.ok !== want_color.ok)
                  report_mismatch("valid_res", 32'(got_color.ok), 32'(want_color.ok));
               if (got_color.argb !== want_color.argb)
                  report_mismatch("argb", got_color.argb, want_color.argb);
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Wait until every item is taken and every color has come back
   task automatic drain();
      while (chars_pending.size() != 0 || req_ch.valid || colors_due.size() != 0)
         @(negedge clock);
   endtask

   // Reset, directed strings, then random strings under four idle patterns
   initial begin
      req_ch.valid = 1'b0;
      req_ch.ch    = 8'h00;
      req_ch.last  = 1'b0;
      rsp_ch.ready = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // NUL alone, whitespace only, inner whitespace, short hex, folded name,
      // padded hex with alpha, too long, and a top-bit byte
      draft.push_back(CHR_NUL);
      flush_draft();
      draft.push_back(CHR_SPACE);
      flush_draft();
      add_text("a b", 0);
      flush_draft();
      add_text("#f0A", 0);
      flush_draft();
      add_text("NoNe", 0);
      flush_draft();
      draft.push_back(CHR_VT);
      add_text("#80fF00c0", 0);
      draft.push_back(CHR_LF);
      flush_draft();
      add_text("Transparent", 0);
      draft.push_back(CHR_BANG);
      flush_draft();
      draft.push_back(CHR_TOP);
      flush_draft();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 79; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 79; end
            default: begin send_idle_pct = 10; rsp_stall_pct = 10; end
         endcase
         phase_chars = 0;
         while (phase_chars < PHASE_CHARS) queue_random_string();
         drain();
      end

      repeat (20) @(negedge clock);
      if (mismatch_count == 0)
         $display("color_string_parser_core verification clean");
      else
         $display("color_string_parser_core verification failed");
      $finish;
   end

   // Stop a hung run
   initial begin
      #2000000;
      $display("color_string_parser_core verification failed");
      $finish;
   end

endmodule
